// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication under active-low reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

// same-cycle implication under active-low reset
`define ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/kfia_pkg.sv =====
// ----------------------------------------------------------------------------
// kfia_pkg
// Types, widths and saturation helpers for the Fisher information accumulator.
// ----------------------------------------------------------------------------
package kfia_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC    = 16;
    localparam int W_W     = 17;
    localparam int ACC_W   = 64;
    localparam int MAG_W   = DATA_W + FRAC;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int TERM_SH = 2 * FRAC + 16 - 32;
    localparam int CIDX_W  = 2;
    localparam int NACC    = 6;

    localparam logic [CIDX_W-1:0] REG_BETA_ONE   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_BETA_TWO   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_BETA_THREE = 2'd2;

    localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC;

    typedef struct packed {
        logic signed [DATA_W-1:0] point_x1;
        logic signed [DATA_W-1:0] point_x2;
        logic        [W_W-1:0]    weight;
        logic                     last_point;
    } t_point;

    typedef struct packed {
        logic signed [ACC_W-1:0] info_00;
        logic signed [ACC_W-1:0] info_01;
        logic signed [ACC_W-1:0] info_02;
        logic signed [ACC_W-1:0] info_11;
        logic signed [ACC_W-1:0] info_12;
        logic signed [ACC_W-1:0] info_22;
        logic                    fault;
    } t_info;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } t_sat;

    function automatic logic [DATA_W-1:0] abs_d(logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // saturate a magnitude with sign to a signed data word
    function automatic t_sat sat_mag(logic [MAG_W-1:0] m, logic neg);
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] v;
        t_sat r;
        lim   = (MAG_W'(1) << (DATA_W - 1)) - (neg ? MAG_W'(0) : MAG_W'(1));
        r.ovf = m > lim;
        v     = r.ovf ? lim : m;
        r.val = neg ? DATA_W'(-v) : DATA_W'(v);
        return r;
    endfunction

endpackage

// ===== rtl/kfia_mul.sv =====
// ----------------------------------------------------------------------------
// kfia_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module kfia_mul
    import kfia_pkg::*;
(
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/kfia_div.sv =====
// ----------------------------------------------------------------------------
// kfia_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfia_div
    import kfia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(MAG_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [MAG_W-1:0]  r_nq;
    logic [DATA_W:0]   rem_sh;
    logic              take;

    assign rem_sh = {r_rem, r_nq[MAG_W-1]};
    assign take   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_nq   <= i_num;
            end else if (r_busy) begin
                r_rem <= take ? DATA_W'(rem_sh - {1'b0, r_den}) : DATA_W'(rem_sh);
                r_nq  <= {r_nq[MAG_W-2:0], take};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

// ===== rtl/kinetics_fisher_information_accumulator.sv =====
// ----------------------------------------------------------------------------
// kinetics_fisher_information_accumulator
// Weighted Fisher information of a rate model over a stream of design points.
// ----------------------------------------------------------------------------
// Use:
//   Write beta_one, beta_two, beta_three on the configuration channel (index
//   0, 1, 2) while idle. Send design points on the point channel; each request
//   is held by a sequencer around one shared 32x32 multiplier and one radix-2
//   divider. A point runs from acceptance through the denominator products, two
//   divisions (start, 48 quotient steps, done), the gradient products, the six
//   terms in turn and a closing state, back to the idle state that takes the
//   next request. With a zero denominator the point skips the divisions and
//   goes straight to the closing state. o_in_ready is low
//   while a point is in work.
//   A point marked last raises o_out_valid from its closing state with the six
//   matrix entries and the sticky fault flag, and the accumulators clear.
//   The result sits in an output register: the next point is taken meanwhile,
//   and only a further last point waits at its end until the receiver takes
//   the pending result.
//   Reset clears accumulators and fault, restores the register defaults and
//   drops any pending result.
// ----------------------------------------------------------------------------
module kinetics_fisher_information_accumulator
    import kfia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_point            i_point,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_info             o_info,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_D1S, S_D1W, S_D2S, S_D2W,
        S_Q1, S_Q2, S_G0I, S_G0C, S_Q3, S_Q4, S_G1I, S_G1C,
        S_TA, S_TB, S_TC, S_TD, S_TE, S_FIN
    } t_state;

    t_state                   r_state;
    logic signed [DATA_W-1:0] r_b1, r_b2, r_b3;
    logic signed [ACC_W-1:0]  r_acc [NACC];
    logic                     r_fault;
    t_point                   r_pt;
    logic signed [DATA_W-1:0] r_t1, r_c, r_r1, r_r2, r_q, r_g0, r_g1;
    logic [DATA_W-1:0]        r_phi;
    logic [PROD_W-1:0]        r_l;
    logic signed [ACC_W-1:0]  r_term;
    logic [2:0]               r_k;
    t_info                    r_out;
    logic                     r_out_valid;

    logic [DATA_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic                     div_start, div_done;
    logic [MAG_W-1:0]         div_num, div_quot;
    logic signed [DATA_W-1:0] gi, gj;
    logic                     mul_neg;
    t_sat                     fm;
    logic signed [DATA_W+1:0] s_sum;
    logic [DATA_W+1:0]        s_mag;
    t_sat                     c_sat;
    logic [3*DATA_W-1:0]      t_full;
    logic [ACC_W-1:0]         t_mag, t_lim, t_val;
    logic                     t_neg, t_ovf;
    logic signed [ACC_W:0]    a_sum;
    logic [ACC_W-1:0]         a_val;
    logic                     a_ovf;

    kfia_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    kfia_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (abs_d(r_c)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        case (r_k)
            3'd0, 3'd1, 3'd2: gi = r_g0;
            3'd3, 3'd4:       gi = r_g1;
            default:          gi = r_r1;
        endcase
        case (r_k)
            3'd0:       gj = r_g0;
            3'd1, 3'd3: gj = r_g1;
            default:    gj = r_r1;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M1:  begin mul_a = abs_d(r_b1); mul_b = abs_d(r_pt.point_x1); end
            S_M2:  begin mul_a = abs_d(r_b2); mul_b = abs_d(r_pt.point_x2); end
            S_Q1:  begin mul_a = abs_d(r_r1); mul_b = abs_d(r_r1); end
            S_G0I, S_G1I: begin mul_a = abs_d(r_b3); mul_b = abs_d(r_q); end
            S_Q3:  begin mul_a = abs_d(r_r1); mul_b = abs_d(r_r2); end
            S_TA:  begin mul_a = abs_d(gi); mul_b = abs_d(gj); end
            S_TB:  begin mul_a = mul_p[DATA_W-1:0]; mul_b = DATA_W'(r_pt.weight); end
            S_TC:  begin mul_a = r_phi; mul_b = DATA_W'(r_pt.weight); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb begin
        case (r_state)
            S_M2:    mul_neg = r_b1[DATA_W-1] ^ r_pt.point_x1[DATA_W-1];
            S_M3:    mul_neg = r_b2[DATA_W-1] ^ r_pt.point_x2[DATA_W-1];
            S_G0C, S_G1C: mul_neg = ~(r_b3[DATA_W-1] ^ r_q[DATA_W-1]);
            S_Q4:    mul_neg = r_r1[DATA_W-1] ^ r_r2[DATA_W-1];
            default: mul_neg = 1'b0;
        endcase
        fm = sat_mag(mul_p[PROD_W-1:FRAC], mul_neg);
    end

    assign s_sum = (DATA_W+2)'(ONE_Q) + (DATA_W+2)'(r_t1) + (DATA_W+2)'(fm.val);
    assign s_mag = s_sum[DATA_W+1] ? (DATA_W+2)'(-s_sum) : (DATA_W+2)'(s_sum);
    assign c_sat = sat_mag(MAG_W'(s_mag), s_sum[DATA_W+1]);

    assign div_start = (r_state == S_D1S) || (r_state == S_D2S);
    assign div_num   = (r_state == S_D1S) ? {abs_d(r_pt.point_x1), FRAC'(0)}
                                          : {abs_d(r_pt.point_x2), FRAC'(0)};

    assign t_neg  = gi[DATA_W-1] ^ gj[DATA_W-1];
    assign t_full = ((3*DATA_W)'(mul_p) << DATA_W) + (3*DATA_W)'(r_l);
    assign t_mag  = t_full[ACC_W+TERM_SH-1:TERM_SH];
    assign t_lim  = (ACC_W'(1) << (ACC_W - 1)) - (t_neg ? ACC_W'(0) : ACC_W'(1));
    assign t_ovf  = (|t_full[3*DATA_W-1:ACC_W+TERM_SH]) || (t_mag > t_lim);
    assign t_val  = t_ovf ? t_lim : t_mag;

    assign a_sum = (ACC_W+1)'(r_acc[r_k]) + (ACC_W+1)'(r_term);
    assign a_ovf = a_sum[ACC_W] != a_sum[ACC_W-1];
    assign a_val = !a_ovf ? a_sum[ACC_W-1:0]
                 : (a_sum[ACC_W] ? (ACC_W'(1) << (ACC_W - 1))
                                 : ~(ACC_W'(1) << (ACC_W - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_b1        <= '0;
            r_b2        <= '0;
            r_b3        <= ONE_Q;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < NACC; i++) r_acc[i] <= '0;
        end else begin
            if (r_out_valid && i_out_ready && !(r_state == S_FIN && r_pt.last_point)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BETA_ONE:   r_b1 <= i_cfg_data;
                    REG_BETA_TWO:   r_b2 <= i_cfg_data;
                    REG_BETA_THREE: r_b3 <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_pt    <= i_point;
                    r_state <= S_M1;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_t1 <= fm.val;
                    if (fm.ovf) r_fault <= 1'b1;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_c <= c_sat.val;
                    if (fm.ovf || c_sat.ovf || c_sat.val == '0) r_fault <= 1'b1;
                    r_state <= (c_sat.val == '0) ? S_FIN : S_D1S;
                end
                S_D1S: r_state <= S_D1W;
                S_D1W: if (div_done) begin
                    c_sat_r1: begin
                        t_sat q;
                        q = sat_mag(div_quot, r_pt.point_x1[DATA_W-1] ^ r_c[DATA_W-1]);
                        r_r1 <= q.val;
                        if (q.ovf) r_fault <= 1'b1;
                    end
                    r_state <= S_D2S;
                end
                S_D2S: r_state <= S_D2W;
                S_D2W: if (div_done) begin
                    c_sat_r2: begin
                        t_sat q;
                        q = sat_mag(div_quot, r_pt.point_x2[DATA_W-1] ^ r_c[DATA_W-1]);
                        r_r2 <= q.val;
                        if (q.ovf) r_fault <= 1'b1;
                    end
                    r_state <= S_Q1;
                end
                S_Q1: r_state <= S_Q2;
                S_Q2: begin
                    r_q <= fm.val;
                    if (fm.ovf) r_fault <= 1'b1;
                    r_state <= S_G0I;
                end
                S_G0I: r_state <= S_G0C;
                S_G0C: begin
                    r_g0 <= fm.val;
                    if (fm.ovf) r_fault <= 1'b1;
                    r_state <= S_Q3;
                end
                S_Q3: r_state <= S_Q4;
                S_Q4: begin
                    r_q <= fm.val;
                    if (fm.ovf) r_fault <= 1'b1;
                    r_state <= S_G1I;
                end
                S_G1I: r_state <= S_G1C;
                S_G1C: begin
                    r_g1 <= fm.val;
                    if (fm.ovf) r_fault <= 1'b1;
                    r_k     <= '0;
                    r_state <= S_TA;
                end
                S_TA: r_state <= S_TB;
                S_TB: begin
                    r_phi   <= mul_p[PROD_W-1:DATA_W];
                    r_state <= S_TC;
                end
                S_TC: begin
                    r_l     <= mul_p;
                    r_state <= S_TD;
                end
                S_TD: begin
                    r_term <= t_neg ? ACC_W'(-t_val) : ACC_W'(t_val);
                    if (t_ovf) r_fault <= 1'b1;
                    r_state <= S_TE;
                end
                S_TE: begin
                    r_acc[r_k] <= a_val;
                    if (a_ovf) r_fault <= 1'b1;
                    r_k     <= r_k + 3'd1;
                    r_state <= (r_k == 3'(NACC - 1)) ? S_FIN : S_TA;
                end
                S_FIN: begin
                    if (!r_pt.last_point) begin
                        r_state <= S_IDLE;
                    end else if (!r_out_valid || i_out_ready) begin
                        r_out.info_00 <= r_acc[0];
                        r_out.info_01 <= r_acc[1];
                        r_out.info_02 <= r_acc[2];
                        r_out.info_11 <= r_acc[3];
                        r_out.info_12 <= r_acc[4];
                        r_out.info_22 <= r_acc[5];
                        r_out.fault   <= r_fault;
                        r_out_valid   <= 1'b1;
                        r_fault       <= 1'b0;
                        for (int i = 0; i < NACC; i++) r_acc[i] <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_info      = r_out;

endmodule

// ===== rtl/kfia_checker.sv =====
// ----------------------------------------------------------------------------
// kfia_checker
// Port-level checks for the Fisher information accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kfia_checker
    import kfia_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   o_in_ready,
    input logic   o_out_valid,
    input logic   i_out_ready,
    input t_info  o_info
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_info))
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, i_in_valid && o_in_ready, !$rose(o_out_valid))

endmodule

bind kinetics_fisher_information_accumulator kfia_checker u_kfia_checker (.*);

// ===== bench/tb_kinetics_fisher_information_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fisher information accumulator testbench
// Streams design points under changing rate parameters and random flow
// control, predicts each matrix result in fixed point and compares it field
// by field with what the block returns.
// ----------------------------------------------------------------------------
import kfia_pkg::*;

class fisher_scoreboard;
    logic signed [DATA_W-1:0] beta [3];
    longint                   acc [NACC];
    bit                       fault;
    t_info                    info_q [$];
    int                       mismatches;

    function new();
        beta[0] = '0;
        beta[1] = '0;
        beta[2] = ONE_Q;
        clear_acc();
        mismatches = 0;
    endfunction

    function void clear_acc();
        foreach (acc[k]) acc[k] = 0;
        fault = 1'b0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            REG_BETA_ONE:   beta[0] = data;
            REG_BETA_TWO:   beta[1] = data;
            REG_BETA_THREE: beta[2] = data;
            default: ;
        endcase
    endfunction

    function logic [127:0] magnitude(longint v);
        return 128'(unsigned'(v < 0 ? -v : v));
    endfunction

    function longint clamp(logic [127:0] m, bit neg, int bits);
        logic [127:0] lim;
        lim = (128'(1) << (bits - 1)) - (neg ? 128'(0) : 128'(1));
        if (m > lim) begin
            fault = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function longint qmul(longint a, longint b, bit negate);
        return clamp((magnitude(a) * magnitude(b)) >> FRAC,
                     (a < 0) ^ (b < 0) ^ negate, DATA_W);
    endfunction

    function longint qdiv(longint x, longint c);
        return clamp((magnitude(x) << FRAC) / magnitude(c), (x < 0) ^ (c < 0), DATA_W);
    endfunction

    function longint acc_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            fault = 1'b1;
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
        end
        return s[63:0];
    endfunction

    function void note_point(t_point p);
        longint s, c, r1, r2, x1, x2, t;
        longint g [3];
        int ri [NACC] = '{0, 0, 0, 1, 1, 2};
        int ci [NACC] = '{0, 1, 2, 1, 2, 2};
        t_info r;
        x1 = longint'(p.point_x1);
        x2 = longint'(p.point_x2);
        s = longint'(ONE_Q) + qmul(longint'(beta[0]), x1, 0) + qmul(longint'(beta[1]), x2, 0);
        c = clamp(magnitude(s), s < 0, DATA_W);
        if (c == 0) begin
            fault = 1'b1;
        end else begin
            r1 = qdiv(x1, c);
            r2 = qdiv(x2, c);
            g[0] = qmul(longint'(beta[2]), qmul(r1, r1, 0), 1);
            g[1] = qmul(longint'(beta[2]), qmul(r1, r2, 0), 1);
            g[2] = r1;
            for (int k = 0; k < NACC; k++) begin
                t = clamp((magnitude(g[ri[k]]) * magnitude(g[ci[k]]) * 128'(p.weight))
                          >> TERM_SH, (g[ri[k]] < 0) ^ (g[ci[k]] < 0), ACC_W);
                acc[k] = acc_add(acc[k], t);
            end
        end
        if (p.last_point) begin
            r.info_00 = acc[0];
            r.info_01 = acc[1];
            r.info_02 = acc[2];
            r.info_11 = acc[3];
            r.info_12 = acc[4];
            r.info_22 = acc[5];
            r.fault   = fault;
            info_q.push_back(r);
            clear_acc();
        end
    endfunction

    function void check_info(t_info got);
        t_info want;
        if (info_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = info_q.pop_front();
        if (got.info_00 !== want.info_00 || got.info_01 !== want.info_01 ||
            got.info_02 !== want.info_02 || got.info_11 !== want.info_11 ||
            got.info_12 !== want.info_12 || got.info_22 !== want.info_22 ||
            got.fault !== want.fault) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch expected 00=%h 01=%h 02=%h 11=%h 12=%h 22=%h f=%b",
                         want.info_00, want.info_01, want.info_02,
                         want.info_11, want.info_12, want.info_22, want.fault);
                $display("         actual   00=%h 01=%h 02=%h 11=%h 12=%h 22=%h f=%b",
                         got.info_00, got.info_01, got.info_02,
                         got.info_11, got.info_12, got.info_22, got.fault);
            end
        end
    endfunction

    function int pending();
        return info_q.size();
    endfunction
endclass

module tb_kinetics_fisher_information_accumulator;
    localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 200;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_point            i_point;
    logic              o_out_valid;
    logic              i_out_ready;
    t_info             o_info;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [DATA_W-1:0] i_cfg_data;

    fisher_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet = 0;

    kinetics_fisher_information_accumulator i_dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) sb.check_info(o_info);
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_point(t_point p);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point    <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point(p);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_beta();
        case ($urandom_range(7))
            0: return '0;
            1: return ONE_Q;
            2: return -ONE_Q;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            5: return 32'h0000_8000;
            6: return $urandom_range(262144) - 131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_coord();
        int r;
        r = $urandom_range(99);
        if (r < 55) return $urandom_range(524288) - 262144;
        if (r < 70) return $urandom_range(33554432) - 16777216;
        if (r < 85) return $urandom;
        case ($urandom_range(4))
            0: return '0;
            1: return ONE_Q;
            2: return -ONE_Q;
            3: return 32'h7fff_ffff;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic t_point pick_point();
        t_point p;
        int r;
        p.point_x1 = pick_coord();
        p.point_x2 = pick_coord();
        r = $urandom_range(99);
        if (r < 70)      p.weight = W_W'($urandom_range(65536));
        else if (r < 90) p.weight = W_W'($urandom_range(131071));
        else             p.weight = (r < 94) ? 17'd0 : (r < 97) ? 17'd65536 : 17'd131071;
        p.last_point = ($urandom_range(15) == 0);
        return p;
    endfunction

    function automatic t_point mk(logic [DATA_W-1:0] x1, logic [DATA_W-1:0] x2,
                                  logic [W_W-1:0] w, logic last);
        t_point p;
        p.point_x1   = x1;
        p.point_x2   = x2;
        p.weight     = w;
        p.last_point = last;
        return p;
    endfunction

    initial begin
        int idle_send [3] = '{25, 63, 0};
        int idle_recv [3] = '{63, 25, 0};
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_point     = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_BETA_ONE;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: extremes of coordinates and weights
        send_point(mk(ONE_Q, ONE_Q, 17'd65536, 1'b1));
        send_point(mk(32'h7fff_ffff, 32'h8000_0000, 17'd131071, 1'b0));
        send_point(mk(32'h8000_0000, 32'h7fff_ffff, 17'd0, 1'b1));
        send_point(mk('0, '0, 17'd65536, 1'b0));
        send_point(mk(32'h0002_0000, -32'sh0003_0000, 17'd131071, 1'b0));
        send_point(mk(32'h0000_0001, 32'hffff_ffff, 17'd1, 1'b1));
        drain();

        // zero denominator: b1 = -1, x1 = 1, x2 = 0
        write_reg(REG_BETA_ONE, -ONE_Q);
        write_reg(REG_BETA_TWO, 32'h0000_8000);
        write_reg(REG_BETA_THREE, -32'sh0002_0000);
        write_reg(REG_SPARE, 32'hffff_ffff);
        send_point(mk(ONE_Q, '0, 17'd65536, 1'b0));
        send_point(mk(32'h0000_4000, 32'h0001_0000, 17'd40000, 1'b1));
        send_point(mk(32'h0000_4000, 32'h0001_0000, 17'd40000, 1'b0));
        send_point(mk(ONE_Q, '0, 17'd131071, 1'b1));
        send_point(mk(32'h0000_8000, 32'hfffe_0000, 17'd65536, 1'b1));
        drain();

        write_reg(REG_BETA_ONE, 32'h7fff_ffff);
        write_reg(REG_BETA_TWO, 32'h8000_0000);
        write_reg(REG_BETA_THREE, 32'h7fff_ffff);
        send_point(mk(32'h0001_0000, 32'h0001_0000, 17'd65536, 1'b1));
        send_point(mk(32'h7fff_ffff, '0, 17'd131071, 1'b0));
        send_point(mk(32'h0000_0100, 32'h0000_0200, 17'd65536, 1'b1));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = idle_send[ph];
            recv_idle = idle_recv[ph];
            for (int s = 0; s < 4; s++) begin
                drain();
                write_reg(REG_BETA_ONE, pick_beta());
                write_reg(REG_BETA_TWO, pick_beta());
                write_reg(REG_BETA_THREE, pick_beta());
                if ($urandom_range(3) == 0) write_reg(REG_SPARE, $urandom);
                for (int n = 0; n < 145; n++) send_point(pick_point());
                send_point(mk(pick_coord(), pick_coord(), W_W'($urandom_range(131071)), 1'b1));
            end
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kfia_pkg.sv
rtl/kfia_mul.sv
rtl/kfia_div.sv
rtl/kinetics_fisher_information_accumulator.sv
rtl/kfia_checker.sv
bench/tb_kinetics_fisher_information_accumulator.sv
